>>> sv/ngf_pkg.sv
// ngf_pkg: shared types, constants and codes for the n-gram frequency counter
// no dependencies; imported by ngf_map, ngf_counters and the core
`timescale 1ns / 1ps

package ngf_pkg;

	// charset and counter sizing
	localparam int CHARSET_MAX = 32;
	localparam int IDX_W       = $clog2(CHARSET_MAX);
	localparam int COUNT_WIDTH = 32;
	localparam int LEN_W       = 32;
	localparam int CODE_W      = 8;

	// history of kept characters for bigram, trigram and skip-grams
	localparam int HIST_N = 5;
	localparam int FILL_W = 3;

	// counter banks, each in a memory of its own
	localparam int NBANK       = 6;
	localparam int BANK_LETTER = 0;
	localparam int BANK_BIGRAM = 1;
	localparam int BANK_TRIGR  = 2;
	localparam int BANK_SKIP3  = 3;
	localparam int BANK_SKIP4  = 4;
	localparam int BANK_SKIP5  = 5;
	localparam int BANK_AW     = 3 * IDX_W;

	// sweep counter covers the largest counter bank and the code map
	localparam int CLR_W = (BANK_AW > CODE_W) ? BANK_AW : CODE_W;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		OP_MAP   = 2'd0,
		OP_START = 2'd1,
		OP_TEXT  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		TBL_LETTER = 3'd0,
		TBL_BIGRAM = 3'd1,
		TBL_TRIGR  = 3'd2,
		TBL_SKIP3  = 3'd3,
		TBL_SKIP4  = 3'd4,
		TBL_SKIP5  = 3'd5
	} tbl_t;

	// clearing sweep after reset
	typedef struct packed {
		logic             active;
		logic [CLR_W-1:0] addr;
	} clr_t;

	// per-bank access issued from stage one
	typedef struct packed {
		logic               inc;
		logic [BANK_AW-1:0] addr;
	} bank_req_t;

	// code map entry
	typedef struct packed {
		logic valid;
		idx_t idx;
	} map_entry_t;

	// address width of each counter bank
	function automatic int bank_aw(input int bank);
		int aw;
		if (bank == BANK_LETTER) aw = IDX_W;
		else if (bank == BANK_TRIGR) aw = 3 * IDX_W;
		else aw = 2 * IDX_W;
		return aw;
	endfunction

	// index lies inside the charset
	function automatic logic idx_ok(input idx_t i);
		return {1'b0, i} < (IDX_W + 1)'(CHARSET_MAX);
	endfunction

endpackage

>>> sv/ngf_ram.sv
// ngf_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module ngf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// registered read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/ngf_map.sv
// ngf_map: character fold and code map memory (code to charset index)
// depends on ngf_pkg and ngf_ram
`timescale 1ns / 1ps

module ngf_map (
	input  logic                       clk,
	input  ngf_pkg::clr_t              clr,
	input  logic                       wr_en,
	input  logic                       rd_en,
	input  logic [ngf_pkg::CODE_W-1:0] char_code,
	input  ngf_pkg::idx_t              char_index,
	output ngf_pkg::map_entry_t        entry
);
	import ngf_pkg::*;

	// upper case to lower, shifted punctuation to its base key
	function automatic logic [CODE_W-1:0] fold(input logic [CODE_W-1:0] c);
		logic [CODE_W-1:0] r;
		r = c;
		if (c >= CODE_W'("A") && c <= CODE_W'("Z")) r = c + CODE_W'(32);
		else if (c == CODE_W'(":")) r = CODE_W'(";");
		else if (c == CODE_W'("\"")) r = CODE_W'("'");
		else if (c == CODE_W'("<")) r = CODE_W'(",");
		else if (c == CODE_W'(">")) r = CODE_W'(".");
		else if (c == CODE_W'("?")) r = CODE_W'("/");
		return r;
	endfunction

	logic              we;
	logic [CODE_W-1:0] waddr;
	map_entry_t        wdata;
	map_entry_t        rdata;

	// the sweep invalidates every entry, otherwise a map word writes one
	assign we          = clr.active || wr_en;
	assign waddr       = clr.active ? clr.addr[CODE_W-1:0] : char_code;
	assign wdata.valid = !clr.active;
	assign wdata.idx   = clr.active ? '0 : char_index;

	ngf_ram #(
		.WIDTH($bits(map_entry_t)),
		.DEPTH(1 << CODE_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (fold(char_code)),
		.rdata (rdata)
	);

	assign entry = rdata;

endmodule

>>> sv/ngf_counters.sv
// ngf_counters: six counter memories with read-modify-write and forwarding
// depends on ngf_pkg and ngf_ram
`timescale 1ns / 1ps

module ngf_counters (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  ngf_pkg::clr_t                                   clr,
	input  logic                                            adv,
	input  ngf_pkg::bank_req_t [ngf_pkg::NBANK-1:0]         req,
	output logic [ngf_pkg::NBANK-1:0][ngf_pkg::COUNT_WIDTH-1:0] base
);
	import ngf_pkg::*;

	logic [NBANK-1:0]                  inc_s2;
	logic [NBANK-1:0]                  fwd_s2;
	logic [NBANK-1:0][BANK_AW-1:0]     addr_s2;
	logic [NBANK-1:0][COUNT_WIDTH-1:0] fwd_q;
	logic [NBANK-1:0][COUNT_WIDTH-1:0] rdata;
	logic [NBANK-1:0][COUNT_WIDTH-1:0] bump;
	logic [NBANK-1:0]                  fwd_s1;

	// an access to the entry that stage two writes now reads the stale word, so the bumped word is forwarded
	always_comb begin
		for (int b = 0; b < NBANK; b++) begin
			fwd_s1[b] = inc_s2[b] && (addr_s2[b] == req[b].addr);
			base[b]   = fwd_s2[b] ? fwd_q[b] : rdata[b];
			bump[b]   = base[b] + COUNT_WIDTH'(1);
		end
	end

	// stage two control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_s2 <= '0;
			fwd_s2 <= '0;
		end else if (adv) begin
			for (int b = 0; b < NBANK; b++) begin
				inc_s2[b] <= req[b].inc;
				fwd_s2[b] <= fwd_s1[b];
			end
		end
	end

	// stage two address and forwarded word
	always_ff @(posedge clk) begin
		for (int b = 0; b < NBANK; b++) begin
			if (adv) addr_s2[b] <= req[b].addr;
			if (adv && inc_s2[b]) fwd_q[b] <= bump[b];
		end
	end

	// one memory per bank, cleared by the sweep after reset
	for (genvar g = 0; g < NBANK; g++) begin : g_bank
		localparam int AW = bank_aw(g);

		logic                   we;
		logic [AW-1:0]          waddr;
		logic [COUNT_WIDTH-1:0] wdata;

		assign we    = clr.active || (adv && inc_s2[g]);
		assign waddr = clr.active ? clr.addr[AW-1:0] : addr_s2[g][AW-1:0];
		assign wdata = clr.active ? '0 : bump[g];

		ngf_ram #(
			.WIDTH(COUNT_WIDTH),
			.DEPTH(1 << AW)
		) u_ram (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (wdata),
			.re    (adv),
			.raddr (req[g].addr[AW-1:0]),
			.rdata (rdata[g])
		);
	end

endmodule

>>> sv/ngram_frequency_counter_core.sv
// ngram_frequency_counter_core: top level, handshake, history and pipeline
// depends on ngf_pkg, ngf_map and ngf_counters
//
// Usage: one input word carries an operation (map a code to a charset index,
// start a new text, count a text character, read a counter) and its fields.
// Every input word gives exactly one output word: accepted, count_value and
// filtered_length. A word is taken at a clock edge with in_valid high and
// in_stall low, and delivered likewise on out_valid / out_stall.
// A taken word passes stage one, stage two and the output register before out_valid
// rises; the block takes one word per cycle back to back while in_stall is low.
// Increments are read-modify-write on six counter memories with a registered
// read; a hit on the entry being written is forwarded, so repeated n-grams
// need no bubble.
// After reset a clearing sweep zeroes all counter memories and invalidates
// the code map; in_stall is high while it runs.
// When the receiver stalls a waiting output word, the whole pipeline holds
// and in_stall rises in the same cycle; the output word stays stable until taken.
`timescale 1ns / 1ps

module ngram_frequency_counter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  char_code,
	input  logic [4:0]  char_index,
	input  logic [2:0]  table_select,
	input  logic [4:0]  first_index,
	input  logic [4:0]  middle_index,
	input  logic [4:0]  last_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [31:0] count_value,
	output logic [31:0] filtered_length
);
	import ngf_pkg::*;

	logic             clr_active_q;
	logic [CLR_W-1:0] clr_addr_q;
	clr_t             clr;
	logic             adv;
	logic             in_fire;

	// stage one
	logic valid_s1;
	op_t  op_s1;
	tbl_t sel_s1;
	idx_t fi_s1, mi_s1, li_s1;

	// history state
	idx_t              hist_q [HIST_N];
	logic [FILL_W-1:0] fill_q;
	logic [LEN_W-1:0]  kept_len_q;
	logic [LEN_W-1:0]  len_next;

	// stage two
	logic             valid_s2;
	op_t              op_s2;
	tbl_t             sel_s2;
	logic             acc_s2;
	logic             rdok_s2;
	logic [LEN_W-1:0] len_s2;

	// output register
	logic                   out_valid_q;
	logic                   acc_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [LEN_W-1:0]       out_len_q;

	map_entry_t                        entry;
	logic                              kept;
	idx_t                              ix;
	logic                              is_text;
	logic                              rdok_s1;
	bank_req_t [NBANK-1:0]             req;
	logic [NBANK-1:0][COUNT_WIDTH-1:0] base;
	logic [COUNT_WIDTH-1:0]            rd_val;
	logic [COUNT_WIDTH-1:0]            count_s2;

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + CLR_W'(1);
			if (clr_addr_q == {CLR_W{1'b1}}) clr_active_q <= 1'b0;
		end
	end

	assign clr.active = clr_active_q;
	assign clr.addr   = clr_addr_q;

	// handshake: the pipeline moves as one while the output slot can take a word
	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = clr_active_q || !adv;
	assign in_fire  = in_valid && !in_stall;

	// code map, written when a map word is taken, read for every word
	ngf_map u_map (
		.clk        (clk),
		.clr        (clr),
		.wr_en      (in_fire && (op_t'(operation) == OP_MAP) && idx_ok(char_index)),
		.rd_en      (adv),
		.char_code  (char_code),
		.char_index (char_index),
		.entry      (entry)
	);

	// stage one registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (adv) valid_s1 <= in_fire;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= op_t'(operation);
			sel_s1 <= tbl_t'(table_select);
			fi_s1  <= first_index;
			mi_s1  <= middle_index;
			li_s1  <= last_index;
		end
	end

	// kept character and read range check
	assign is_text = (op_s1 == OP_TEXT);
	assign kept    = valid_s1 && is_text && entry.valid;
	assign ix      = entry.idx;

	always_comb begin
		unique case (sel_s1)
			TBL_LETTER: rdok_s1 = idx_ok(li_s1);
			TBL_TRIGR:  rdok_s1 = idx_ok(fi_s1) && idx_ok(mi_s1) && idx_ok(li_s1);
			default:    rdok_s1 = idx_ok(fi_s1) && idx_ok(li_s1);
		endcase
	end

	// counter addresses: n-grams ending in ix for text, the fields for a read
	always_comb begin
		req[BANK_LETTER].addr = is_text ? BANK_AW'(ix) : BANK_AW'(li_s1);
		req[BANK_BIGRAM].addr = is_text ? BANK_AW'({hist_q[0], ix})
		                                : BANK_AW'({fi_s1, li_s1});
		req[BANK_TRIGR].addr  = is_text ? BANK_AW'({hist_q[1], hist_q[0], ix})
		                                : BANK_AW'({fi_s1, mi_s1, li_s1});
		req[BANK_SKIP3].addr  = is_text ? BANK_AW'({hist_q[2], ix})
		                                : BANK_AW'({fi_s1, li_s1});
		req[BANK_SKIP4].addr  = is_text ? BANK_AW'({hist_q[3], ix})
		                                : BANK_AW'({fi_s1, li_s1});
		req[BANK_SKIP5].addr  = is_text ? BANK_AW'({hist_q[4], ix})
		                                : BANK_AW'({fi_s1, li_s1});
		req[BANK_LETTER].inc  = kept;
		req[BANK_BIGRAM].inc  = kept && (fill_q >= FILL_W'(1));
		req[BANK_TRIGR].inc   = kept && (fill_q >= FILL_W'(2));
		req[BANK_SKIP3].inc   = kept && (fill_q >= FILL_W'(3));
		req[BANK_SKIP4].inc   = kept && (fill_q >= FILL_W'(4));
		req[BANK_SKIP5].inc   = kept && (fill_q >= FILL_W'(5));
	end

	ngf_counters u_counters (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.adv    (adv),
		.req    (req),
		.base   (base)
	);

	// filtered length after this word
	always_comb begin
		len_next = kept_len_q;
		if (valid_s1 && op_s1 == OP_START) len_next = '0;
		else if (kept) len_next = kept_len_q + LEN_W'(1);
	end

	// history shift on a kept character, cleared on start of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int h = 0; h < HIST_N; h++) hist_q[h] <= '0;
			fill_q     <= '0;
			kept_len_q <= '0;
		end else if (adv) begin
			kept_len_q <= len_next;
			if (valid_s1 && op_s1 == OP_START) begin
				for (int h = 0; h < HIST_N; h++) hist_q[h] <= '0;
				fill_q <= '0;
			end else if (kept) begin
				for (int h = HIST_N - 1; h > 0; h--) hist_q[h] <= hist_q[h-1];
				hist_q[0] <= ix;
				if (fill_q < FILL_W'(HIST_N)) fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// stage two registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (adv) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_s1;
			sel_s2  <= sel_s1;
			acc_s2  <= kept;
			rdok_s2 <= rdok_s1;
			len_s2  <= len_next;
		end
	end

	// read result select
	always_comb begin
		unique case (sel_s2)
			TBL_LETTER: rd_val = base[BANK_LETTER];
			TBL_BIGRAM: rd_val = base[BANK_BIGRAM];
			TBL_TRIGR:  rd_val = base[BANK_TRIGR];
			TBL_SKIP3:  rd_val = base[BANK_SKIP3];
			TBL_SKIP4:  rd_val = base[BANK_SKIP4];
			TBL_SKIP5:  rd_val = base[BANK_SKIP5];
			default:    rd_val = '0;
		endcase
	end

	assign count_s2 = (op_s2 == OP_READ && rdok_s2) ? rd_val : '0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_q     <= acc_s2;
			count_q   <= count_s2;
			out_len_q <= len_s2;
		end
	end

	assign out_valid       = out_valid_q;
	assign accepted        = acc_q;
	assign count_value     = count_q;
	assign filtered_length = out_len_q;

endmodule

>>> test/tb.sv
// tb: self-checking testbench for ngram_frequency_counter_core
// depends on ngf_pkg and the core; drives words, predicts each result word and compares
`timescale 1ns / 1ps

module tb;
	import ngf_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 200;
	localparam int IDLE_PERCENT = 27;
	localparam int TAIL_CYCLES  = 8;
	localparam int RANDOM_WORDS = 500;

	// table selects outside the six counter banks
	localparam logic [2:0] TBL_SPARE_LO = 3'd6;
	localparam logic [2:0] TBL_SPARE_HI = 3'd7;

	// character codes that the block folds, their folded forms and the ends of the code range
	localparam logic [7:0] CH_A_UP   = "A";
	localparam logic [7:0] CH_A_LOW  = "a";
	localparam logic [7:0] CH_COLON  = ":";
	localparam logic [7:0] CH_SEMI   = ";";
	localparam logic [7:0] CH_DQUOTE = "\"";
	localparam logic [7:0] CH_QUOTE  = "'";
	localparam logic [7:0] CH_LT     = "<";
	localparam logic [7:0] CH_COMMA  = ",";
	localparam logic [7:0] CH_GT     = ">";
	localparam logic [7:0] CH_DOT    = ".";
	localparam logic [7:0] CH_QMARK  = "?";
	localparam logic [7:0] CH_SLASH  = "/";
	localparam logic [7:0] CH_Z_UP   = "Z";
	localparam logic [7:0] CODE_LOW  = 8'h00;
	localparam logic [7:0] CODE_HIGH = 8'hFF;
	localparam int CASE_SHIFT = 32;

	typedef struct {
		op_t        op;
		logic [7:0] code;
		idx_t       cidx;
		logic [2:0] sel;
		idx_t       fi;
		idx_t       mi;
		idx_t       li;
	} word_t;

	typedef struct {
		logic        acc;
		logic [31:0] cnt;
		logic [31:0] len;
	} tally_t;

	typedef struct {
		word_t  w;
		bit     typed;
		tally_t want;
	} script_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  operation = '0;
	logic [7:0]  char_code = '0;
	logic [4:0]  char_index = '0;
	logic [2:0]  table_select = '0;
	logic [4:0]  first_index = '0;
	logic [4:0]  middle_index = '0;
	logic [4:0]  last_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        accepted;
	logic [31:0] count_value;
	logic [31:0] filtered_length;

	// shadow state of the counter
	bit          map_ok [256];
	idx_t        map_ix [256];
	idx_t        hist [HIST_N];
	int          hist_fill;
	bit [31:0]   kept_len;
	bit [31:0]   letter_cnt [CHARSET_MAX];
	bit [31:0]   bigram_cnt [CHARSET_MAX * CHARSET_MAX];
	bit [31:0]   trigram_cnt [CHARSET_MAX * CHARSET_MAX * CHARSET_MAX];
	bit [31:0]   skip_cnt [3 * CHARSET_MAX * CHARSET_MAX];

	tally_t      expected_tallies [$];
	script_row_t script [$];
	int          mismatches = 0;
	int          cycle_count = 0;
	logic        steady = 1'b0;
	logic        hold_request = 1'b0;
	logic        sink_hold = 1'b0;

	ngram_frequency_counter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.char_code(char_code),
		.char_index(char_index),
		.table_select(table_select),
		.first_index(first_index),
		.middle_index(middle_index),
		.last_index(last_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.accepted(accepted),
		.count_value(count_value),
		.filtered_length(filtered_length)
	);

	always #2 clk = ~clk;

	// upper case to lower, shifted punctuation to its base key
	function automatic logic [7:0] fold_char(input logic [7:0] c);
		logic [7:0] f;
		f = c;
		if (c >= CH_A_UP && c <= CH_Z_UP) f = c + 8'(CASE_SHIFT);
		else if (c == CH_COLON) f = CH_SEMI;
		else if (c == CH_DQUOTE) f = CH_QUOTE;
		else if (c == CH_LT) f = CH_COMMA;
		else if (c == CH_GT) f = CH_DOT;
		else if (c == CH_QMARK) f = CH_SLASH;
		return f;
	endfunction

	// counter lookup for a read word
	function automatic logic [31:0] counter_at(input word_t w);
		logic [31:0] v;
		v = '0;
		case (w.sel)
			TBL_LETTER: v = letter_cnt[w.li];
			TBL_BIGRAM: v = bigram_cnt[{w.fi, w.li}];
			TBL_TRIGR:  v = trigram_cnt[{w.fi, w.mi, w.li}];
			TBL_SKIP3, TBL_SKIP4, TBL_SKIP5: v = skip_cnt[{2'(w.sel - TBL_SKIP3), w.fi, w.li}];
			default:    v = '0;
		endcase
		return v;
	endfunction

	// advance the shadow state by one word and give the result it should produce
	function automatic tally_t predict_tally(input word_t w);
		tally_t     t;
		logic [7:0] f;
		idx_t       ix;
		t = '{1'b0, 32'd0, 32'd0};
		case (w.op)
			OP_MAP: begin
				map_ok[w.code] = 1'b1;
				map_ix[w.code] = w.cidx;
			end
			OP_START: begin
				for (int k = 0; k < HIST_N; k++) hist[k] = '0;
				hist_fill = 0;
				kept_len = '0;
			end
			OP_TEXT: begin
				f = fold_char(w.code);
				if (map_ok[f]) begin
					ix = map_ix[f];
					letter_cnt[ix] += 1;
					if (hist_fill >= 1) bigram_cnt[{hist[0], ix}] += 1;
					if (hist_fill >= 2) trigram_cnt[{hist[1], hist[0], ix}] += 1;
					// skip-grams at distance three, four and five
					for (int k = 0; k < 3; k++)
						if (hist_fill >= k + 3) skip_cnt[{2'(k), hist[k + 2], ix}] += 1;
					for (int k = HIST_N - 1; k > 0; k--) hist[k] = hist[k - 1];
					hist[0] = ix;
					if (hist_fill < HIST_N) hist_fill++;
					kept_len += 1;
					t.acc = 1'b1;
				end
			end
			OP_READ: t.cnt = counter_at(w);
			default: ;
		endcase
		t.len = kept_len;
		return t;
	endfunction

	// offer one word, with random gaps, until the block takes it
	task automatic offer_word(input word_t w);
		while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= w.op;
		char_code    <= w.code;
		char_index   <= w.cidx;
		table_select <= w.sel;
		first_index  <= w.fi;
		middle_index <= w.mi;
		last_index   <= w.li;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
	endtask

	task automatic put_row(input op_t op, input logic [7:0] code, input idx_t cidx,
			input logic [2:0] sel, input idx_t fi, input idx_t mi, input idx_t li,
			input bit typed, input logic acc, input logic [31:0] cnt,
			input logic [31:0] len);
		script_row_t r;
		r.w = '{op, code, cidx, sel, fi, mi, li};
		r.typed = typed;
		r.want = '{acc, cnt, len};
		script.push_back(r);
	endtask

	// wait for every outstanding result word
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_tallies.size() != 0) @(posedge clk);
	endtask

	// printable-ish text, weighted toward codes that get folded or mapped
	function automatic logic [7:0] pick_text_code();
		int r;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 40) c = CH_A_LOW + 8'($urandom_range(0, 25));
		else if (r < 60) c = CH_A_UP + 8'($urandom_range(0, 25));
		else if (r < 75) begin
			case ($urandom_range(0, 9))
				0: c = CH_COLON;
				1: c = CH_SEMI;
				2: c = CH_DQUOTE;
				3: c = CH_QUOTE;
				4: c = CH_LT;
				5: c = CH_COMMA;
				6: c = CH_GT;
				7: c = CH_DOT;
				8: c = CH_QMARK;
				default: c = CH_SLASH;
			endcase
		end else c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// result side: check each taken word, then decide the next stall
	always @(posedge clk) begin
		tally_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_tallies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("tb: unexpected word acc %0d cnt %0d len %0d",
						accepted, count_value, filtered_length);
			end else begin
				want = expected_tallies.pop_front();
				if (accepted !== want.acc || count_value !== want.cnt ||
						filtered_length !== want.len) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: mismatch exp acc %0d cnt %0d len %0d, got acc %0d cnt %0d len %0d",
							want.acc, want.cnt, want.len,
							accepted, count_value, filtered_length);
				end
			end
		end
		out_stall <= sink_hold || (!steady && $urandom_range(0, 99) < IDLE_PERCENT);
	end

	// long receiver hold-off so the pipeline backs up into in_stall
	initial begin
		wait (hold_request === 1'b1);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		word_t  w;
		tally_t want;
		int     r;

		// directed words: reset state, folding, remap, short history, spare tables
		put_row(OP_READ, CODE_LOW, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b0, 0, 0);
		put_row(OP_READ, CODE_LOW, 5'd0, TBL_SPARE_HI, 5'd31, 5'd31, 5'd31, 1, 1'b0, 0, 0);
		put_row(OP_TEXT, CH_A_LOW, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b0, 0, 0);
		put_row(OP_MAP, CH_A_LOW, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b0, 0, 0);
		put_row(OP_MAP, CH_SEMI, 5'd31, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b0, 0, 0);
		put_row(OP_MAP, CODE_HIGH, 5'd17, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b0, 0, 0);
		put_row(OP_MAP, CODE_LOW, 5'd5, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b0, 0, 0);
		put_row(OP_TEXT, CH_A_UP, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b1, 0, 1);
		put_row(OP_TEXT, CH_COLON, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b1, 0, 2);
		put_row(OP_MAP, CH_A_LOW, 5'd30, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b0, 0, 2);
		put_row(OP_TEXT, CH_A_LOW, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b1, 0, 3);
		put_row(OP_TEXT, CODE_HIGH, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b1, 0, 4);
		put_row(OP_TEXT, CODE_LOW, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b1, 0, 5);
		put_row(OP_TEXT, CH_DQUOTE, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b0, 0, 5);
		put_row(OP_TEXT, CH_A_LOW, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b1, 0, 6);
		put_row(OP_READ, CODE_LOW, 5'd0, TBL_BIGRAM, 5'd0, 5'd0, 5'd31, 0, 1'b0, 0, 0);
		put_row(OP_READ, CODE_LOW, 5'd0, TBL_TRIGR, 5'd0, 5'd31, 5'd30, 0, 1'b0, 0, 0);
		put_row(OP_READ, CODE_LOW, 5'd0, TBL_SKIP3, 5'd0, 5'd0, 5'd17, 0, 1'b0, 0, 0);
		put_row(OP_READ, CODE_LOW, 5'd0, TBL_SKIP4, 5'd31, 5'd0, 5'd30, 0, 1'b0, 0, 0);
		put_row(OP_READ, CODE_LOW, 5'd0, TBL_SKIP5, 5'd0, 5'd0, 5'd30, 0, 1'b0, 0, 0);
		put_row(OP_READ, CODE_HIGH, 5'd31, TBL_SPARE_LO, 5'd31, 5'd31, 5'd31, 1, 1'b0, 0, 6);
		put_row(OP_START, CODE_HIGH, 5'd31, TBL_SPARE_HI, 5'd31, 5'd31, 5'd31, 1, 1'b0, 0, 0);
		put_row(OP_MAP, CH_QUOTE, 5'd1, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b0, 0, 0);
		put_row(OP_TEXT, CH_DQUOTE, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd0, 1, 1'b1, 0, 1);
		put_row(OP_READ, CODE_LOW, 5'd0, TBL_LETTER, 5'd0, 5'd0, 5'd1, 0, 1'b0, 0, 0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			offer_word(script[i].w);
			want = predict_tally(script[i].w);
			expected_tallies.push_back(script[i].typed ? script[i].want : want);
		end

		// random part: seed the charset, then a text stream with maps, starts and reads
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == 120) hold_request <= 1'b1;
			if (i == 250) drain;
			steady <= (i >= 320 && i < 420);

			w.code = 8'($urandom_range(0, 255));
			w.cidx = 5'($urandom_range(0, 31));
			w.sel  = 3'($urandom_range(0, 7));
			w.fi   = 5'($urandom_range(0, 31));
			w.mi   = 5'($urandom_range(0, 31));
			w.li   = 5'($urandom_range(0, 31));
			r = $urandom_range(0, 99);
			if (i < 26) begin
				w.op = OP_MAP;
				w.code = CH_A_LOW + 8'(i);
			end else if (i < 31) begin
				w.op = OP_MAP;
				w.code = fold_char(pick_text_code());
			end else if (r < 8) begin
				w.op = OP_MAP;
				if ($urandom_range(0, 99) < 70) w.code = pick_text_code();
			end else if (r < 12) begin
				w.op = OP_START;
			end else if (r < 70) begin
				w.op = OP_TEXT;
				w.code = pick_text_code();
			end else begin
				w.op = OP_READ;
				// half the time aim at n-grams that the recent text produced
				if ($urandom_range(0, 1) == 1) begin
					w.fi = hist[$urandom_range(0, HIST_N - 1)];
					w.mi = hist[$urandom_range(0, 1)];
					w.li = hist[$urandom_range(0, 1)];
				end
			end
			offer_word(w);
			expected_tallies.push_back(predict_tally(w));
		end

		drain;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

>>> sim.f
sv/ngf_pkg.sv
sv/ngf_ram.sv
sv/ngf_map.sv
sv/ngf_counters.sv
sv/ngram_frequency_counter_core.sv
test/tb.sv
